### sv/fuzzy_key_reconstruct_secded_defines.svh
// Assertion macros shared by the key reconstruction RTL.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef FUZZY_KEY_RECONSTRUCT_SECDED_DEFINES_SVH
`define FUZZY_KEY_RECONSTRUCT_SECDED_DEFINES_SVH

// Plain property, checked every clock outside reset.
`define FKR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define FKR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/fkr_pkg.sv
// Shared types, syndrome codes and the Hamming(8,4) parity function.
// No dependencies; used by fkr_decode and the top level.
package fkr_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned NIB_W   = 4;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;

  // syndrome codes pointing at a data bit
  localparam logic [2:0] SYN_NONE = 3'd0;
  localparam logic [2:0] SYN_D1   = 3'd3;
  localparam logic [2:0] SYN_D2   = 3'd5;
  localparam logic [2:0] SYN_D3   = 3'd6;
  localparam logic [2:0] SYN_D4   = 3'd7;

  typedef struct packed {
    logic       dbl;       // uncorrectable error in either nibble
    logic [1:0] n_single;  // corrected single errors in this byte
  } dec_stat_t;

  // parity nibble: {overall, p3, p2, p1}
  function automatic logic [NIB_W-1:0] parity_of(input logic [NIB_W-1:0] d);
    logic p1, p2, p3, pall;
    p1   = d[0] ^ d[1] ^ d[3];
    p2   = d[0] ^ d[2] ^ d[3];
    p3   = d[1] ^ d[2] ^ d[3];
    pall = ^d ^ p1 ^ p2 ^ p3;
    return {pall, p3, p2, p1};
  endfunction

endpackage

### sv/fkr_decode.sv
// SECDED check and correction of one byte (two nibbles), then mask XOR.
// Pure combinational; depends on fkr_pkg.
module fkr_decode (
  input  logic [fkr_pkg::BYTE_W-1:0] noisy,
  input  logic [fkr_pkg::BYTE_W-1:0] parity,
  input  logic [fkr_pkg::BYTE_W-1:0] mask,
  output logic [fkr_pkg::BYTE_W-1:0] key_byte,
  output fkr_pkg::dec_stat_t         stat
);

  logic [fkr_pkg::NIB_W-1:0] diff_lo, diff_hi;
  logic [fkr_pkg::NIB_W-1:0] fix_lo, fix_hi;
  logic                      dbl_lo, dbl_hi, sgl_lo, sgl_hi;

  // flip pattern for a syndrome; parity-only syndromes leave the data alone
  function automatic logic [fkr_pkg::NIB_W-1:0] flip_of(input logic [2:0] syn);
    logic [fkr_pkg::NIB_W-1:0] f;
    case (syn)
      fkr_pkg::SYN_D1: f = 4'b0001;
      fkr_pkg::SYN_D2: f = 4'b0010;
      fkr_pkg::SYN_D3: f = 4'b0100;
      fkr_pkg::SYN_D4: f = 4'b1000;
      default:         f = 4'b0000;
    endcase
    return f;
  endfunction

  assign diff_lo = fkr_pkg::parity_of(noisy[3:0]) ^ parity[3:0];
  assign diff_hi = fkr_pkg::parity_of(noisy[7:4]) ^ parity[7:4];

  // overall parity clear but syndrome set: double error
  assign dbl_lo = !diff_lo[3] && (diff_lo[2:0] != fkr_pkg::SYN_NONE);
  assign dbl_hi = !diff_hi[3] && (diff_hi[2:0] != fkr_pkg::SYN_NONE);
  assign sgl_lo = diff_lo[3];
  assign sgl_hi = diff_hi[3];

  assign fix_lo = sgl_lo ? (noisy[3:0] ^ flip_of(diff_lo[2:0])) : noisy[3:0];
  assign fix_hi = sgl_hi ? (noisy[7:4] ^ flip_of(diff_hi[2:0])) : noisy[7:4];

  assign key_byte      = {fix_hi, fix_lo} ^ mask;
  assign stat.dbl      = dbl_lo || dbl_hi;
  assign stat.n_single = {1'b0, sgl_lo} + {1'b0, sgl_hi};

endmodule

### sv/fuzzy_key_reconstruct_secded.sv
// Key reconstruction: one PUF byte per beat, SECDED correction, mask XOR.
// Slave beat: noisy PUF byte, helper parity byte, mask byte; tlast marks
// the final byte of a key. Master beat: recovered key byte with status.
// Each byte's two nibbles are checked against extended Hamming(8,4)
// parity; single errors are corrected and counted, double errors flag the
// byte and set a sticky per-key failure flag.
// Each beat passes through the input register, then the result register.
// Throughput: one byte per cycle while out_tready is high, set by the single
// decode stage feeding the running error counter.
// The error count (saturating at 255) and failure flag cover the current
// key and clear after the tlast result is computed.
// Reset clears both valid stages, the count and the flag.
// When out_tready is low, the result register holds and one more beat is
// taken into the input register; in_tready then drops until space frees.
// Depends on fkr_pkg, fkr_decode and fuzzy_key_reconstruct_secded_defines.svh.
`include "fuzzy_key_reconstruct_secded_defines.svh"

module fuzzy_key_reconstruct_secded (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] noisy_byte, [15:8] parity_byte, [23:16] mask_byte
  input  logic [fkr_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] key_byte, [8] double_error, [9] key_failed, [17:10] error_total,
  // [23:18] zero
  output logic [fkr_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast
);

  localparam int unsigned BW = fkr_pkg::BYTE_W;
  localparam int unsigned CW = fkr_pkg::CNT_W;

  // input register
  logic          s1_valid_r;
  logic [BW-1:0] s1_noisy_r, s1_parity_r, s1_mask_r;
  logic          s1_last_r;

  // result register
  logic          out_valid_r;
  logic [BW-1:0] out_key_r;
  logic          out_dbl_r, out_fail_r, out_last_r;
  logic [CW-1:0] out_total_r;

  // per-key state
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          fail_r, fail_nxt;

  logic               out_free, s1_adv, in_acc;
  logic [BW-1:0]      dec_key;
  fkr_pkg::dec_stat_t dec_stat;
  logic [CW:0]        cnt_sum;
  logic [CW-1:0]      cnt_upd;
  logic               fail_upd;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  fkr_decode u_dec (
    .noisy    (s1_noisy_r),
    .parity   (s1_parity_r),
    .mask     (s1_mask_r),
    .key_byte (dec_key),
    .stat     (dec_stat)
  );

  // saturating count; at most two added per byte
  always_comb begin
    cnt_sum  = {1'b0, cnt_r} + {{(CW-1){1'b0}}, dec_stat.n_single};
    cnt_upd  = cnt_sum[CW] ? {CW{1'b1}} : cnt_sum[CW-1:0];
    fail_upd = fail_r || dec_stat.dbl;
    cnt_nxt  = cnt_r;
    fail_nxt = fail_r;
    if (s1_adv) begin
      cnt_nxt  = s1_last_r ? '0 : cnt_upd;
      fail_nxt = s1_last_r ? 1'b0 : fail_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      fail_r      <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      fail_r <= fail_nxt;
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_noisy_r  <= in_tdata[7:0];
      s1_parity_r <= in_tdata[15:8];
      s1_mask_r   <= in_tdata[23:16];
      s1_last_r   <= in_tlast;
    end
    if (s1_adv) begin
      out_key_r   <= dec_key;
      out_dbl_r   <= dec_stat.dbl;
      out_fail_r  <= fail_upd;
      out_total_r <= cnt_upd;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_total_r, out_fail_r, out_dbl_r, out_key_r};
  assign out_tlast  = out_last_r;

  `FKR_ASSERT_NEXT(a_clear_after_last, s1_adv && s1_last_r, cnt_r == '0 && !fail_r,
    "key state not cleared after last byte")
  `FKR_ASSERT_NEXT(a_cnt_monotonic, s1_adv && !s1_last_r, cnt_r >= $past(cnt_r),
    "error count dropped within a key")
  `FKR_ASSERT(a_dbl_sets_fail, !(out_valid_r && out_dbl_r && !out_fail_r),
    "double error without key failure")
  `FKR_ASSERT(a_stall_only_full, in_tready || (s1_valid_r && out_valid_r && !out_tready),
    "input stalled with room to spare")

endmodule
